// File: design/lbf_pkg.sv
// Package for the learning bridge forwarder.
// Holds the transfer payload structs and the shared constants; no dependencies.
package lbf_pkg;

  localparam int unsigned AddrW           = 48;
  localparam int unsigned LenW            = 16;
  localparam int unsigned CntW            = 32;
  localparam int unsigned GroupBit        = 40;
  localparam int unsigned MinFrameBytes   = 14;
  localparam int unsigned TableEntriesDef = 16;

  typedef struct packed {
    logic [AddrW-1:0] dest_address;
    logic [AddrW-1:0] source_address;
    logic [LenW-1:0]  frame_length;
    logic             arrival_port;
  } lbf_in_t;

  typedef struct packed {
    logic            egress_port;
    logic            dropped;
    logic            flooded;
    logic [CntW-1:0] drop_count;
    logic [CntW-1:0] a_to_b_count;
    logic [CntW-1:0] b_to_a_count;
  } lbf_out_t;

endpackage

// File: design/lbf_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; contents are undefined until written.
module lbf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/learning_bridge_forwarder_top.sv
// Top level of the two-port learning bridge forwarder.
// Depends on lbf_pkg for payload types and constants and on lbf_ram for the MAC table.

// Each header transfer runs one at a time through a sequencer around a single 48-bit
// comparator that scans the MAC table RAM one entry per cycle with a registered read.
// A frame shorter than 14 bytes goes from acceptance straight to the result.
// Otherwise the source scan, the table write, the destination scan (skipped for
// a group destination) and the result follow in that order; a hit ends a scan
// early. The next header is taken as soon as the result is in the output
// register, while that result waits to be taken. Table entries that were never
// written read as all ones with port A through one valid bit per entry, so
// there is no clearing pass after reset.
module learning_bridge_forwarder_top
  import lbf_pkg::*;
#(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  lbf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lbf_out_t out_data_o
);

  localparam int unsigned IdxW   = $clog2(TableEntries);
  localparam int unsigned EntryW = AddrW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESULT
  } state_e;

  state_e              state_q;
  lbf_in_t             item_q;
  logic                lookup_q;
  logic                rd_act_q;
  logic [IdxW-1:0]     rd_idx_q;
  logic                cmp_vld_q;
  logic [IdxW-1:0]     cmp_idx_q;
  logic [IdxW-1:0]     tgt_q;
  logic                miss_q;
  logic [IdxW-1:0]     ptr_q;
  logic [TableEntries-1:0] valid_q;
  logic                egress_q;
  logic                drop_q;
  logic                flood_q;
  logic [CntW-1:0]     drop_cnt_q;
  logic [CntW-1:0]     ab_cnt_q;
  logic [CntW-1:0]     ba_cnt_q;
  logic                out_valid_q;
  lbf_out_t            out_data_q;

  logic [CntW-1:0]     drop_cnt_d;
  logic [CntW-1:0]     ab_cnt_d;
  logic [CntW-1:0]     ba_cnt_d;
  logic [EntryW-1:0]   rdata;
  logic [AddrW-1:0]    entry_addr;
  logic                entry_port;
  logic [AddrW-1:0]    key;
  logic                match;
  logic                cmp_last;
  logic                rd_en;
  logic                wr_en;
  logic                short_frame;
  logic                dst_group;

  assign rd_en = (state_q == ST_SCAN) && rd_act_q;
  assign wr_en = (state_q == ST_WRITE);

  lbf_ram #(
    .Width(EntryW),
    .Depth(TableEntries)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(tgt_q),
    .wdata_i({item_q.arrival_port, item_q.source_address}),
    .re_i   (rd_en),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  assign entry_addr  = valid_q[cmp_idx_q] ? rdata[AddrW-1:0] : '1;
  assign entry_port  = valid_q[cmp_idx_q] ? rdata[EntryW-1] : 1'b0;
  assign key         = lookup_q ? item_q.dest_address : item_q.source_address;
  assign match       = cmp_vld_q && (entry_addr == key);
  assign cmp_last    = (cmp_idx_q == IdxW'(TableEntries - 1));
  assign short_frame = in_data_i.frame_length < LenW'(MinFrameBytes);
  assign dst_group   = item_q.dest_address[GroupBit];

  assign drop_cnt_d = drop_cnt_q + CntW'(drop_q);
  assign ab_cnt_d   = ab_cnt_q + CntW'(!drop_q && !item_q.arrival_port);
  assign ba_cnt_d   = ba_cnt_q + CntW'(!drop_q && item_q.arrival_port);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      lookup_q    <= 1'b0;
      rd_act_q    <= 1'b0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      tgt_q       <= '0;
      miss_q      <= 1'b0;
      ptr_q       <= '0;
      valid_q     <= '0;
      egress_q    <= 1'b0;
      drop_q      <= 1'b0;
      flood_q     <= 1'b0;
      drop_cnt_q  <= '0;
      ab_cnt_q    <= '0;
      ba_cnt_q    <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            if (short_frame) begin
              drop_q   <= 1'b1;
              flood_q  <= 1'b0;
              egress_q <= 1'b0;
              state_q  <= ST_RESULT;
            end else begin
              drop_q    <= 1'b0;
              lookup_q  <= 1'b0;
              rd_idx_q  <= '0;
              rd_act_q  <= 1'b1;
              cmp_vld_q <= 1'b0;
              state_q   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          cmp_vld_q <= rd_act_q;
          cmp_idx_q <= rd_idx_q;
          if (rd_act_q) begin
            if (rd_idx_q == IdxW'(TableEntries - 1)) begin
              rd_act_q <= 1'b0;
            end else begin
              rd_idx_q <= rd_idx_q + 1'b1;
            end
          end
          if (match) begin
            rd_act_q  <= 1'b0;
            cmp_vld_q <= 1'b0;
            if (!lookup_q) begin
              tgt_q   <= cmp_idx_q;
              miss_q  <= 1'b0;
              state_q <= ST_WRITE;
            end else begin
              egress_q <= entry_port;
              flood_q  <= 1'b0;
              state_q  <= ST_RESULT;
            end
          end else if (cmp_vld_q && cmp_last) begin
            rd_act_q  <= 1'b0;
            cmp_vld_q <= 1'b0;
            if (!lookup_q) begin
              tgt_q   <= ptr_q;
              miss_q  <= 1'b1;
              state_q <= ST_WRITE;
            end else begin
              egress_q <= ~item_q.arrival_port;
              flood_q  <= 1'b1;
              state_q  <= ST_RESULT;
            end
          end
        end
        ST_WRITE: begin
          valid_q[tgt_q] <= 1'b1;
          if (miss_q) begin
            if (ptr_q == IdxW'(TableEntries - 1)) begin
              ptr_q <= '0;
            end else begin
              ptr_q <= ptr_q + 1'b1;
            end
          end
          if (dst_group) begin
            egress_q <= ~item_q.arrival_port;
            flood_q  <= 1'b1;
            state_q  <= ST_RESULT;
          end else begin
            lookup_q  <= 1'b1;
            rd_idx_q  <= '0;
            rd_act_q  <= 1'b1;
            cmp_vld_q <= 1'b0;
            state_q   <= ST_SCAN;
          end
        end
        ST_RESULT: begin
          if (!out_valid_q || out_ready_i) begin
            drop_cnt_q               <= drop_cnt_d;
            ab_cnt_q                 <= ab_cnt_d;
            ba_cnt_q                 <= ba_cnt_d;
            out_data_q.egress_port   <= egress_q;
            out_data_q.dropped       <= drop_q;
            out_data_q.flooded       <= flood_q;
            out_data_q.drop_count    <= drop_cnt_d;
            out_data_q.a_to_b_count  <= ab_cnt_d;
            out_data_q.b_to_a_count  <= ba_cnt_d;
            out_valid_q              <= 1'b1;
            state_q                  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
